// ----- src/histogram_battery_gauge_core_macros.svh -----
// Assertion macros for the histogram battery gauge.
// Included by the top level; expects clk and rst in scope.
`ifndef HISTOGRAM_BATTERY_GAUGE_CORE_MACROS_SVH
`define HISTOGRAM_BATTERY_GAUGE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HBG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HBG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBG_ASSERT_IMP(lbl, ante, cons, msg)
`define HBG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/hbg_pkg.sv -----
// Shared types and constants for the histogram battery gauge.
// No dependencies; imported by the top level and hbg_div (hbg_ram does not use it).
`timescale 1ns / 1ps

package hbg_pkg;

  localparam int BUCKET_BITS  = 5;
  localparam int ADC_BITS     = 12;
  localparam int BUCKET_SHIFT = ADC_BITS - BUCKET_BITS;
  localparam int BUCKET_COUNT = 1 << BUCKET_BITS;

  localparam int OP_W     = 3;
  localparam int COUNT_W  = 16;
  localparam int TOTAL_W  = 21;
  localparam int ACC_W    = TOTAL_W + 1;
  localparam int LEVEL_W  = 7;
  localparam int SCALE_W  = 10;                          // holds 1000
  localparam int PCT_W    = 7;                           // holds 100
  localparam int PER_W    = COUNT_W + SCALE_W - BUCKET_SHIFT;
  localparam int DIV_W    = ACC_W + PCT_W;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [SCALE_W-1:0] PER_MILLE   = SCALE_W'(1000);
  localparam logic [TOTAL_W-1:0] MILLE_DIV   = TOTAL_W'(1000);
  localparam logic [DIV_W-1:0]   PERCENT_MUL = DIV_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_QUERY = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SUM,
    S_MUL2,
    S_DIV1,
    S_MUL3,
    S_DIV2,
    S_UPD,
    S_RDOUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [TOTAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/histogram_battery_gauge_core.sv -----
// Histogram battery gauge: top level with sequencer, bucket store and datapath.
// Depends on hbg_pkg, hbg_ram, hbg_div and the assertion macro header.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | opcode, reading, bucket_index, bucket_value
//   out     | out_valid / out_stall| level, level_known, bucket_data
//
// Clear, unused opcodes and trivial queries go from accept through dispatch straight
// to the result; add, write and read pass one more state (update or readout). A full
// query walks the lower buckets on the store's one read port, then makes
// two 29-step passes through the serial divider (/1000, then /total).
// Reset clears the per-bucket valid bits and the total at once; no clearing pass.
// in_stall is high while an item is in work; a result waits in the output register
// while out_stall is high, and the next item can be accepted meanwhile.
`timescale 1ns / 1ps
`include "histogram_battery_gauge_core_macros.svh"

module histogram_battery_gauge_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hbg_pkg::OP_W-1:0]    opcode,
  input  logic [hbg_pkg::ADC_BITS-1:0] reading,
  input  logic [hbg_pkg::BUCKET_BITS-1:0] bucket_index,
  input  logic [hbg_pkg::COUNT_W-1:0] bucket_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hbg_pkg::LEVEL_W-1:0] level,
  output logic                        level_known,
  output logic [hbg_pkg::COUNT_W-1:0] bucket_data
);
  import hbg_pkg::*;

  state_t state, state_next;

  // latched item
  op_t                    op_q;
  logic [ADC_BITS-1:0]    rd_q;
  logic [BUCKET_BITS-1:0] bidx_q;
  logic [COUNT_W-1:0]     bval_q;

  // histogram state
  logic [BUCKET_COUNT-1:0] valid;
  logic                    valid_q;
  logic [TOTAL_W-1:0]      total;

  // query datapath
  logic [BUCKET_BITS-1:0] ptr;
  logic [TOTAL_W-1:0]     acc;
  logic [PER_W-1:0]       per;
  logic [ACC_W-1:0]       interp;

  // pending result
  logic [LEVEL_W-1:0] res_level;
  logic               res_known;
  logic [COUNT_W-1:0] res_data;

  // store ports
  logic                   ram_we;
  logic [BUCKET_BITS-1:0] ram_waddr;
  logic [COUNT_W-1:0]     ram_wdata;
  logic [BUCKET_BITS-1:0] ram_raddr;
  logic [COUNT_W-1:0]     ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [BUCKET_BITS-1:0]       rd_idx;
  logic [BUCKET_SHIFT-1:0]      rel;
  logic [COUNT_W-1:0]           cnt_eff;
  logic [COUNT_W+SCALE_W-1:0]   scaled;
  logic                         accept;
  logic                         out_free;

  assign rd_idx   = rd_q[ADC_BITS-1 -: BUCKET_BITS];
  assign rel      = rd_q[BUCKET_SHIFT-1:0];
  assign cnt_eff  = valid_q ? ram_rdata : '0;  // never-written entries read as zero
  assign scaled   = {{SCALE_W{1'b0}}, cnt_eff} * {{COUNT_W{1'b0}}, PER_MILLE};
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  hbg_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BUCKET_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hbg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, store and divider control
  always_comb begin
    state_next       = state;
    in_stall         = 1'b1;
    ram_raddr        = '0;
    ram_we           = 1'b0;
    ram_waddr        = (op_q == OP_ADD) ? rd_idx : bidx_q;
    ram_wdata        = bval_q;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_W-BUCKET_SHIFT){1'b0}}, rel} * {{(DIV_W-PER_W){1'b0}}, per};
    div_req.divisor  = MILLE_DIV;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_q)
          OP_ADD: begin
            ram_raddr  = rd_idx;
            state_next = S_UPD;
          end
          OP_WRITE: begin
            ram_raddr  = bidx_q;
            state_next = S_UPD;
          end
          OP_READ: begin
            ram_raddr  = bidx_q;
            state_next = S_RDOUT;
          end
          OP_QUERY: begin
            ram_raddr  = '0;
            state_next = (total == '0 || rd_q == '0) ? S_DONE : S_SUM;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SUM: begin
        if (ptr == rd_idx) begin
          state_next = S_MUL2;
        end else begin
          ram_raddr = ptr + BUCKET_BITS'(1);
        end
      end
      S_MUL2: begin
        div_req.start = 1'b1;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_next = S_MUL3;
        end
      end
      S_MUL3: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(DIV_W-ACC_W){1'b0}}, interp} * PERCENT_MUL;
        div_req.divisor  = total;
        state_next       = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_UPD: begin
        if (op_q == OP_ADD) begin
          ram_we    = (cnt_eff != COUNT_MAX);  // saturating bucket
          ram_wdata = cnt_eff + COUNT_W'(1);
        end else begin
          ram_we = 1'b1;
        end
        state_next = S_DONE;
      end
      S_RDOUT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state: valid bits, total, output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DISPATCH && op_q == OP_CLEAR) begin
        valid <= '0;
        total <= '0;
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
        if (op_q == OP_ADD) begin
          total <= total + TOTAL_W'(1);
        end else begin
          total <= total - TOTAL_W'(cnt_eff) + TOTAL_W'(bval_q);
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    valid_q <= valid[ram_raddr];
    if (accept) begin
      op_q   <= op_t'(opcode);
      rd_q   <= reading;
      bidx_q <= bucket_index;
      bval_q <= bucket_value;
    end
    case (state)
      S_DISPATCH: begin
        res_level <= '0;
        res_known <= (op_q == OP_QUERY) && (total != '0);
        res_data  <= '0;
        ptr       <= '0;
        acc       <= '0;
      end
      S_SUM: begin
        if (ptr == rd_idx) begin
          per <= scaled[COUNT_W+SCALE_W-1:BUCKET_SHIFT];
        end else begin
          acc <= acc + TOTAL_W'(cnt_eff);
          ptr <= ptr + BUCKET_BITS'(1);
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          interp <= div_rsp.quotient[ACC_W-1:0] + {1'b0, acc};
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          res_level <= (div_rsp.quotient > {{(DIV_W-LEVEL_W){1'b0}}, LEVEL_MAX})
                       ? LEVEL_MAX : div_rsp.quotient[LEVEL_W-1:0];
        end
      end
      S_RDOUT: begin
        res_data <= cnt_eff;
      end
      default: begin
      end
    endcase
    if (state == S_DONE && out_free) begin
      level       <= res_level;
      level_known <= res_known;
      bucket_data <= res_data;
    end
  end

  `HBG_ASSERT_IMP(a_level_range, out_valid, level <= LEVEL_MAX, "level above 100")
  `HBG_ASSERT_IMP(a_level_known, out_valid && level != '0, level_known, "level without known total")
  `HBG_ASSERT_IMP(a_data_alone, out_valid && bucket_data != '0, level == '0 && !level_known, "bucket data mixed with level")
  `HBG_ASSERT_NXT(a_accept_dispatch, accept, state == S_DISPATCH, "accepted item not dispatched")

endmodule

// ----- src/hbg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module hbg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hbg_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Uses hbg_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module hbg_div (
  input  logic              clk,
  input  logic              rst,
  input  hbg_pkg::div_req_t req,
  output hbg_pkg::div_rsp_t rsp
);
  import hbg_pkg::*;

  logic [TOTAL_W-1:0] rem;
  logic [DIV_W-1:0]   quo;
  logic [TOTAL_W-1:0] dvs;
  logic [DCNT_W-1:0]  cnt;
  logic               busy;
  logic               done;

  logic [TOTAL_W:0]   shifted;
  logic [TOTAL_W:0]   diff;
  logic               fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= DCNT_W'(DIV_W);
    end else if (busy) begin
      rem <= fits ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
      cnt <= cnt - DCNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- bench/gauge_checker.sv -----
`timescale 1ns / 1ps
// Result checker for histogram_battery_gauge_core: mirrors the bucket store and the total,
// predicts every result and compares the results in order. Depends on hbg_pkg only.
module gauge_checker
  import hbg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [OP_W-1:0]        opcode,
  input  logic [ADC_BITS-1:0]    reading,
  input  logic [BUCKET_BITS-1:0] bucket_index,
  input  logic [COUNT_W-1:0]     bucket_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [LEVEL_W-1:0]     level,
  input  logic                   level_known,
  input  logic [COUNT_W-1:0]     bucket_data,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               known;
    logic [COUNT_W-1:0] data;
  } gauge_result_t;

  logic [COUNT_W-1:0] tally [BUCKET_COUNT];
  logic [TOTAL_W-1:0] tally_sum;
  gauge_result_t      awaited [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] gauge mismatch: %s", $time, msg);
    errors++;
  endtask

  // Percent level for a nonzero reading with a nonzero total.
  function automatic logic [LEVEL_W-1:0] level_percent(input logic [ADC_BITS-1:0] rd);
    longint unsigned below, per_mille, offset, cum, pct;
    int slot;
    below  = 0;
    slot   = int'(rd[ADC_BITS-1:BUCKET_SHIFT]);
    offset = rd[BUCKET_SHIFT-1:0];
    for (int q = 0; q < slot; q++)
      below += tally[q];
    per_mille = tally[slot];
    per_mille = (per_mille * PER_MILLE) >> BUCKET_SHIFT;
    cum = offset * per_mille / PER_MILLE + below;
    pct = cum * PERCENT_MUL / tally_sum;
    return (pct > LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(pct);
  endfunction

  // Applies one command to the mirrored store and returns its result.
  function automatic gauge_result_t apply_command(input logic [OP_W-1:0] op,
                                                  input logic [ADC_BITS-1:0] rd,
                                                  input logic [BUCKET_BITS-1:0] bi,
                                                  input logic [COUNT_W-1:0] bv);
    gauge_result_t r;
    logic [BUCKET_BITS-1:0] slot;
    r    = '0;
    slot = rd[ADC_BITS-1:BUCKET_SHIFT];
    case (op)
      OP_CLEAR: begin
        foreach (tally[q]) tally[q] = '0;
        tally_sum = '0;
      end
      OP_ADD: begin
        // a full bucket saturates and the total stops with it
        if (tally[slot] != COUNT_MAX) begin
          tally[slot] = tally[slot] + 1'b1;
          tally_sum   = tally_sum + 1'b1;
        end
      end
      OP_QUERY: begin
        if (tally_sum != '0) begin
          r.known = 1'b1;
          if (rd != '0) r.level = level_percent(rd);
        end
      end
      OP_WRITE: begin
        tally_sum = tally_sum - tally[bi] + bv;
        tally[bi] = bv;
      end
      OP_READ: r.data = tally[bi];
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : track
    gauge_result_t want;
    if (rst) begin
      foreach (tally[q]) tally[q] = '0;
      tally_sum = '0;
    end else begin
      // results first: a result never belongs to the item taken at the same edge
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("result with none awaited (level %0d known %0b data %0d)",
                                  level, level_known, bucket_data));
        end else begin
          want = awaited.pop_front();
          if (level !== want.level)
            flag_mismatch($sformatf("level %0d, expected %0d", level, want.level));
          if (level_known !== want.known)
            flag_mismatch($sformatf("level_known %0b, expected %0b", level_known, want.known));
          if (bucket_data !== want.data)
            flag_mismatch($sformatf("bucket_data %0d, expected %0d", bucket_data, want.data));
        end
      end
      if (in_valid && !in_stall)
        awaited.push_back(apply_command(opcode, reading, bucket_index, bucket_value));
    end
    pending = awaited.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for histogram_battery_gauge_core: clock, reset, command stimulus with
// random idling on both channels, and the verdict. Depends on hbg_pkg, gauge_checker and the core.
module tb;
  import hbg_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_AFTER   = 700;   // items sent before the long output hold-off
  localparam int HOLD_CYCLES  = 600;
  // opcodes past the last defined one; the block must answer them with zeros
  localparam logic [OP_W-1:0] OP_SPARE_BASE = OP_W'(int'(OP_READ) + 1);

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        opcode;
  logic [ADC_BITS-1:0]    reading;
  logic [BUCKET_BITS-1:0] bucket_index;
  logic [COUNT_W-1:0]     bucket_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [LEVEL_W-1:0]     level;
  logic                   level_known;
  logic [COUNT_W-1:0]     bucket_data;

  int errors;
  int pending;
  int items_sent = 0;
  bit quiet_tx   = 1'b0;   // sender offers back to back
  bit quiet_rx   = 1'b0;   // receiver adds no random stall
  bit hold_off   = 1'b0;   // long receiver stall, driven by its own process

  histogram_battery_gauge_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .reading      (reading),
    .bucket_index (bucket_index),
    .bucket_value (bucket_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .level_known  (level_known),
    .bucket_data  (bucket_data)
  );

  gauge_checker gauge_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .reading      (reading),
    .bucket_index (bucket_index),
    .bucket_value (bucket_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .level_known  (level_known),
    .bucket_data  (bucket_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one item: optional idle gap, then valid held with a steady payload
  // until the block takes it. Entered and left at a falling edge.
  task automatic offer_command(input logic [OP_W-1:0] op,
                               input logic [ADC_BITS-1:0] rd,
                               input logic [BUCKET_BITS-1:0] bi,
                               input logic [COUNT_W-1:0] bv);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    reading      <= rd;
    bucket_index <= bi;
    bucket_value <= bv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    int pick;
    logic [OP_W-1:0]        op;
    logic [ADC_BITS-1:0]    rd;
    logic [BUCKET_BITS-1:0] bi;
    logic [BUCKET_BITS-1:0] hot;
    logic [COUNT_W-1:0]     bv;

    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_CLEAR;
    reading      = '0;
    bucket_index = '0;
    bucket_value = '0;
    hot          = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty store, zero reading, top of range, full bucket, spare opcodes.
    offer_command(OP_QUERY, 12'd100, '0, '0);          // empty histogram -> unknown
    offer_command(OP_READ, '0, '0, '0);
    offer_command(OP_ADD, '0, '0, '0);
    offer_command(OP_ADD, '1, '1, '1);
    offer_command(OP_ADD, 12'd2048, '0, '0);
    offer_command(OP_QUERY, '0, '1, '1);               // zero reading -> level 0, known
    offer_command(OP_QUERY, '1, '0, '0);
    offer_command(OP_QUERY, 12'd2100, '0, '0);
    offer_command(OP_WRITE, '0, '1, COUNT_MAX);
    offer_command(OP_ADD, '1, '0, '0);                 // bucket already full
    offer_command(OP_READ, '0, '1, '0);
    offer_command(OP_QUERY, 12'd4000, '0, '0);
    offer_command(OP_WRITE, '1, '0, '0);
    offer_command(OP_WRITE, '0, '0, COUNT_MAX);
    offer_command(OP_READ, '1, '0, '1);
    offer_command(OP_QUERY, '1, '0, '0);
    offer_command(OP_SPARE_BASE, '1, '1, '1);
    offer_command(OP_SPARE_BASE + 3'd1, '1, '1, '1);
    offer_command(OP_SPARE_BASE + 3'd2, '1, '1, '1);
    offer_command(OP_CLEAR, '1, '1, '1);
    offer_command(OP_QUERY, '1, '0, '0);               // cleared again -> unknown
    offer_command(OP_READ, '0, '1, '0);
    offer_command(OP_WRITE, '0, 5'd16, 16'd1);
    offer_command(OP_QUERY, 12'd2175, '0, '0);         // last reading of a bucket

    // Random: mostly adds and queries, with writes that park a bucket near full
    // so that later adds into it run into saturation.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      rd   = ADC_BITS'($urandom);
      bi   = BUCKET_BITS'($urandom);
      bv   = COUNT_W'($urandom);
      if (pick < 2) begin
        op = OP_CLEAR;
      end else if (pick < 5) begin
        op = OP_SPARE_BASE + OP_W'($urandom_range(0, 2));
      end else if (pick < 45) begin
        op = OP_ADD;
        if ($urandom_range(0, 1) == 1) rd[ADC_BITS-1:BUCKET_SHIFT] = hot;
      end else if (pick < 70) begin
        op = OP_QUERY;
        case ($urandom_range(0, 7))
          0: rd = '0;
          1: rd = '1;
          2: rd[BUCKET_SHIFT-1:0] = '0;
          3: rd[BUCKET_SHIFT-1:0] = '1;
          4: rd[ADC_BITS-1:BUCKET_SHIFT] = hot;
          default: ;
        endcase
      end else if (pick < 85) begin
        op = OP_WRITE;
        case ($urandom_range(0, 4))
          0: bv = '0;
          1: begin
            bv  = COUNT_MAX - COUNT_W'($urandom_range(0, 3));
            hot = bi;
          end
          2: bv = COUNT_W'($urandom_range(0, 15));
          default: ;
        endcase
      end else begin
        op = OP_READ;
        if ($urandom_range(0, 1) == 1) bi = hot;
      end
      offer_command(op, rd, bi, bv);
    end
    in_valid <= 1'b0;

    // Drain, then give a stray result time to show up.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stall before each result, quiet stretches, and the long hold.
  initial begin : result_drain
    int hold;
    int taken;
    out_stall = 1'b0;
    taken     = 0;
    forever begin
      if (taken % 100 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      hold = quiet_rx ? 0 : $urandom_range(0, 16);
      if (hold > 0 || hold_off) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        while (hold_off) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // Long output hold-off while the sender keeps offering: the output register
  // fills, the next item finishes behind it, and the input side has to stall.
  initial begin : output_hold
    while (items_sent < HOLD_AFTER) @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog, about ten times the slowest legal run.
  initial begin : watchdog
    #25_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/hbg_pkg.sv
src/hbg_ram.sv
src/hbg_div.sv
src/histogram_battery_gauge_core.sv
bench/gauge_checker.sv
bench/tb.sv
